// File: sv/lsra_pkg.sv
package lsra_pkg;

    localparam int NUM_REGS_DEF = 16;
    localparam int POS_BITS_DEF = 16;
    localparam int ID_BITS_DEF  = 10;
    localparam int SPILL_W      = 16;
    localparam int REGNUM_W     = 4;

    typedef enum logic [1:0] {
        ST_ASSIGNED     = 2'd0,
        ST_NEW_SPILL    = 2'd1,
        ST_VICTIM_SPILL = 2'd2,
        ST_SKIPPED      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPIRE,
        S_DECIDE,
        S_VICTIM,
        S_ASSIGN,
        S_SPILL
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    expire;
        logic    replace;
        logic    spill_new;
        logic    alloc;
        logic    insert;
        logic    load_out;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic fixed;
        logic pressure;
        logic replace;
        logic out_free;
    } stat_t;

endpackage

// File: sv/linear_scan_register_allocator.sv
// Flow: an interval is accepted in S_IDLE. A fixed interval gives a skipped
// result beat from S_EXPIRE; others expire, then S_DECIDE assigns, spills the
// new interval, or spills a victim (S_VICTIM beat) before S_ASSIGN. A new
// interval is accepted only back in S_IDLE; a pending unaccepted beat stalls.
// Reset (aresetn low, synchronous): active list empty, all registers free,
// spill count zero, no result beat pending.
module linear_scan_register_allocator
    import lsra_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_first_of_function,
    input  logic [ID_BITS-1:0]  s_interval_id,
    input  logic [POS_BITS-1:0] s_start_point,
    input  logic [POS_BITS-1:0] s_end_point,
    input  logic                s_can_spill,
    input  logic                s_is_fixed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ID_BITS-1:0]  m_result_id,
    output logic [1:0]          m_status,
    output logic [REGNUM_W-1:0] m_register_number,
    output logic [SPILL_W-1:0]  m_spill_total,
    output logic                m_last
);

    cmd_t  cmd;
    stat_t stat;

    lsra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lsra_dpath #(
        .NUM_REGS (NUM_REGS),
        .POS_BITS (POS_BITS),
        .ID_BITS  (ID_BITS)
    ) u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_first_of_function (s_first_of_function),
        .s_interval_id       (s_interval_id),
        .s_start_point       (s_start_point),
        .s_end_point         (s_end_point),
        .s_can_spill         (s_can_spill),
        .s_is_fixed          (s_is_fixed),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_id         (m_result_id),
        .m_status            (m_status),
        .m_register_number   (m_register_number),
        .m_spill_total       (m_spill_total),
        .m_last              (m_last)
    );

endmodule

// File: sv/lsra_ctrl.sv
module lsra_ctrl
    import lsra_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = ST_ASSIGNED;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (stat.fixed) begin
                    if (stat.out_free) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_SKIPPED;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.expire = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.pressure) begin
                    if (stat.replace) begin
                        cmd.replace = 1'b1;
                        state_next  = S_VICTIM;
                    end else begin
                        cmd.spill_new = 1'b1;
                        state_next    = S_SPILL;
                    end
                end else begin
                    cmd.alloc  = 1'b1;
                    state_next = S_ASSIGN;
                end
            end
            S_VICTIM: begin
                if (stat.out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_VICTIM_SPILL;
                    state_next     = S_ASSIGN;
                end
            end
            S_ASSIGN: begin
                if (stat.out_free) begin
                    cmd.insert     = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_ASSIGNED;
                    state_next     = S_IDLE;
                end
            end
            S_SPILL: begin
                if (stat.out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_NEW_SPILL;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/lsra_dpath.sv
module lsra_dpath
    import lsra_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                s_first_of_function,
    input  logic [ID_BITS-1:0]  s_interval_id,
    input  logic [POS_BITS-1:0] s_start_point,
    input  logic [POS_BITS-1:0] s_end_point,
    input  logic                s_can_spill,
    input  logic                s_is_fixed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ID_BITS-1:0]  m_result_id,
    output logic [1:0]          m_status,
    output logic [REGNUM_W-1:0] m_register_number,
    output logic [SPILL_W-1:0]  m_spill_total,
    output logic                m_last
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CNT_W = $clog2(NUM_REGS + 1);

    typedef struct packed {
        logic [POS_BITS-1:0] ep;
        logic [IDX_W-1:0]    rn;
        logic [ID_BITS-1:0]  id;
        logic                sp;
    } entry_t;

    entry_t               ent_reg  [NUM_REGS];
    entry_t               ent_next [NUM_REGS];
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_REGS-1:0]  free_reg, free_next;
    logic [SPILL_W-1:0]   spill_reg, spill_next;

    logic [ID_BITS-1:0]   id_in_reg, id_in_next;
    logic [POS_BITS-1:0]  start_in_reg, start_in_next;
    logic [POS_BITS-1:0]  end_in_reg, end_in_next;
    logic                 sp_in_reg, sp_in_next;
    logic                 fixed_in_reg, fixed_in_next;
    logic [IDX_W-1:0]     r_reg, r_next;
    logic [ID_BITS-1:0]   vid_reg, vid_next;

    logic                 m_valid_reg, m_valid_next;
    logic [ID_BITS-1:0]   m_id_reg, m_id_next;
    status_t              m_status_reg, m_status_next;
    logic [REGNUM_W-1:0]  m_rnum_reg, m_rnum_next;
    logic [SPILL_W-1:0]   m_spill_reg, m_spill_next;
    logic                 m_last_reg, m_last_next;

    logic [CNT_W-1:0]     exp_k;
    logic [NUM_REGS-1:0]  exp_free;
    logic [IDX_W-1:0]     vic_idx;
    logic [CNT_W-1:0]     ins_p;
    logic [IDX_W-1:0]     low_free;
    logic [SPILL_W-1:0]   spill_inc;
    entry_t               new_ent;

    always_comb begin
        exp_k    = '0;
        exp_free = '0;
        vic_idx  = IDX_W'(count_reg - CNT_W'(1));
        ins_p    = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (i < int'(count_reg)) begin
                if (start_in_reg > ent_reg[i].ep) begin
                    exp_k = CNT_W'(i + 1);
                    exp_free[ent_reg[i].rn] = 1'b1;
                end
                if (ent_reg[i].sp) begin
                    vic_idx = IDX_W'(i);
                end
                if (!(end_in_reg < ent_reg[i].ep)) begin
                    ins_p = CNT_W'(i + 1);
                end
            end
        end
    end

    always_comb begin
        low_free = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                low_free = IDX_W'(i);
            end
        end
    end

    assign spill_inc     = (spill_reg == '1) ? spill_reg : spill_reg + SPILL_W'(1);
    assign stat.fixed    = fixed_in_reg;
    assign stat.pressure = (count_reg == CNT_W'(NUM_REGS));
    assign stat.replace  = (end_in_reg < ent_reg[vic_idx].ep) || !sp_in_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        new_ent.ep = end_in_reg;
        new_ent.rn = r_reg;
        new_ent.id = id_in_reg;
        new_ent.sp = sp_in_reg;
    end

    always_comb begin
        ent_next      = ent_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        spill_next    = spill_reg;
        id_in_next    = id_in_reg;
        start_in_next = start_in_reg;
        end_in_next   = end_in_reg;
        sp_in_next    = sp_in_reg;
        fixed_in_next = fixed_in_reg;
        r_next        = r_reg;
        vid_next      = vid_reg;

        if (cmd.load_in) begin
            id_in_next    = s_interval_id;
            start_in_next = s_start_point;
            end_in_next   = s_end_point;
            sp_in_next    = s_can_spill;
            fixed_in_next = s_is_fixed;
            if (s_first_of_function) begin
                count_next = '0;
                free_next  = '1;
                spill_next = '0;
            end
        end

        // drop the expired prefix and release its registers
        if (cmd.expire) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                for (int j = 0; j < NUM_REGS - i; j++) begin
                    if (j == int'(exp_k)) begin
                        ent_next[i] = ent_reg[i + j];
                    end
                end
            end
            count_next = count_reg - exp_k;
            free_next  = free_reg | exp_free;
        end

        if (cmd.replace) begin
            for (int i = 0; i < NUM_REGS - 1; i++) begin
                if (i >= int'(vic_idx)) begin
                    ent_next[i] = ent_reg[i + 1];
                end
            end
            count_next = count_reg - CNT_W'(1);
            spill_next = spill_inc;
            r_next     = ent_reg[vic_idx].rn;
            vid_next   = ent_reg[vic_idx].id;
        end

        if (cmd.spill_new) begin
            spill_next = spill_inc;
        end

        if (cmd.alloc) begin
            r_next              = low_free;
            free_next[low_free] = 1'b0;
        end

        if (cmd.insert) begin
            for (int i = 1; i < NUM_REGS; i++) begin
                if (i > int'(ins_p)) begin
                    ent_next[i] = ent_reg[i - 1];
                end
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i == int'(ins_p)) begin
                    ent_next[i] = new_ent;
                end
            end
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_id_next     = m_id_reg;
        m_status_next = m_status_reg;
        m_rnum_next   = m_rnum_reg;
        m_spill_next  = m_spill_reg;
        m_last_next   = m_last_reg;
        if (cmd.load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = cmd.out_status;
            m_id_next     = (cmd.out_status == ST_VICTIM_SPILL) ? vid_reg : id_in_reg;
            m_rnum_next   = (cmd.out_status == ST_ASSIGNED) ? REGNUM_W'(r_reg) : '0;
            m_spill_next  = spill_reg;
            m_last_next   = (cmd.out_status != ST_VICTIM_SPILL);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            free_reg    <= '1;
            spill_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            free_reg    <= free_next;
            spill_reg   <= spill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg      <= ent_next;
        id_in_reg    <= id_in_next;
        start_in_reg <= start_in_next;
        end_in_reg   <= end_in_next;
        sp_in_reg    <= sp_in_next;
        fixed_in_reg <= fixed_in_next;
        r_reg        <= r_next;
        vid_reg      <= vid_next;
        m_id_reg     <= m_id_next;
        m_status_reg <= m_status_next;
        m_rnum_reg   <= m_rnum_next;
        m_spill_reg  <= m_spill_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_result_id       = m_id_reg;
    assign m_status          = m_status_reg;
    assign m_register_number = m_rnum_reg;
    assign m_spill_total     = m_spill_reg;
    assign m_last            = m_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= NUM_REGS)
        else $error("active count above register pool");

    // one register may be held outside both the pool and the list
    a_regs_conserved: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(free_reg) + int'(count_reg)) <= NUM_REGS)
        else $error("free and active registers exceed the pool");

    a_spill_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.load_in |=> spill_reg >= $past(spill_reg))
        else $error("spill count dropped without a clear");

    a_victim_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> m_status_reg == ST_VICTIM_SPILL)
        else $error("non-final beat that is not a victim spill");
`endif

endmodule
